>>> rtl/tmhf_pkg.sv
// ============================================================================
// tmhf_pkg : shared types and helpers for the template min-Hamming filter
// Function codes, the aggregate that sweeps down the cell chain, the
// broadcast command to the cells and the symbol distance function.
// ============================================================================
package tmhf_pkg;

    // Symbols per template, two bits each
    localparam int SYMBOLS = 32;
    localparam int WORD_W  = 64;
    localparam int DIST_W  = 6;
    // Survivor count wraps at the field width, which matches the result field
    localparam int SURV_W  = 7;

    // Request function codes
    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_GRAM   = 2'd1,
        FUNC_REPORT = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    // Result kind codes
    localparam logic KIND_GRAM   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Command broadcast from the top level to every cell
    typedef struct packed {
        logic              gram;
        logic [WORD_W-1:0] word;
        logic [DIST_W-1:0] init;
        logic [DIST_W-1:0] keep_floor;
    } t_cell_cmd;

    // Running aggregate handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [SURV_W-1:0] count;
        logic [DIST_W-1:0] best_dist;
        logic [WORD_W-1:0] tmpl;
    } t_agg;

    // Number of mismatching symbols between two packed words
    function automatic logic [DIST_W-1:0] sym_distance(input logic [WORD_W-1:0] a,
                                                       input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] eq;
        logic [DIST_W-1:0] part [32];
        eq = ~(a ^ b);
        // one match bit per symbol, unused symbols count as no match
        for (int i = 0; i < 32; i++) begin
            if (i < SYMBOLS) begin
                part[i] = {{(DIST_W-1){1'b0}}, eq[2*i] & eq[2*i+1]};
            end else begin
                part[i] = '0;
            end
        end
        // five-level adder tree
        for (int w = 16; w >= 1; w = w >> 1) begin
            for (int i = 0; i < w; i++) begin
                part[i] = part[2*i] + part[2*i+1];
            end
        end
        return DIST_W'(SYMBOLS) - part[0];
    endfunction

endpackage

>>> rtl/tmhf_if.sv
// ============================================================================
// tmhf_if : request and result channels of the template filter
// Valid/ready channels; source drives valid and payload, sink drives ready.
// ============================================================================
interface tmhf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [63:0] word;
    logic [5:0]  initial_distance;

    modport source (output valid, output func, output word, output initial_distance,
                    input ready);
    modport sink (input valid, input func, input word, input initial_distance,
                  output ready);
endinterface

interface tmhf_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [6:0]  survivors;
    logic [63:0] best_template;
    logic [5:0]  best_distance;
    logic        none_live;

    modport source (output valid, output kind, output survivors, output best_template,
                    output best_distance, output none_live, input ready);
    modport sink (input valid, input kind, input survivors, input best_template,
                  input best_distance, input none_live, output ready);
endinterface

>>> rtl/tmhf_cell.sv
// ============================================================================
// tmhf_cell : one template slot of the filter chain
// Holds a template, its running minimum and a live flag. Applies grams in
// parallel with all other cells and folds itself into the sweeping aggregate.
// ============================================================================
module tmhf_cell
    import tmhf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_cell_cmd i_cmd,
    input  t_agg      i_agg,
    output t_agg      o_agg
);

    logic              r_live;
    logic [WORD_W-1:0] r_tmpl;
    logic [DIST_W-1:0] r_dist;
    t_agg              r_agg;

    logic              n_live;
    logic [WORD_W-1:0] n_tmpl;
    logic [DIST_W-1:0] n_dist;
    t_agg              n_agg;
    logic [DIST_W-1:0] w_d;
    logic              w_take;

    // gram distance against the stored template
    assign w_d = sym_distance(i_cmd.word, r_tmpl);

    // slot update: load, or tighten / drop on a gram
    always_comb begin
        n_live = r_live;
        n_tmpl = r_tmpl;
        n_dist = r_dist;
        priority if (i_load) begin
            n_live = 1'b1;
            n_tmpl = i_cmd.word;
            n_dist = i_cmd.init;
        end else if (i_cmd.gram && r_live && (w_d < r_dist)) begin
            if (w_d >= i_cmd.keep_floor) begin
                n_dist = w_d;
            end else begin
                n_live = 1'b0;
            end
        end
    end

    // fold this slot into the aggregate; strict compare keeps the earliest
    assign w_take = r_live && (!i_agg.found || (r_dist > i_agg.best_dist));

    always_comb begin
        n_agg       = i_agg;
        n_agg.count = i_agg.count + SURV_W'(r_live);
        n_agg.found = i_agg.found | r_live;
        if (w_take) begin
            n_agg.best_dist = r_dist;
            n_agg.tmpl      = r_tmpl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= 1'b0;
            r_agg.valid <= 1'b0;
        end else begin
            r_live <= n_live;
            r_agg  <= n_agg;
        end
    end

    // slot payload, meaningful only once loaded
    always_ff @(posedge i_clk) begin
        r_tmpl <= n_tmpl;
        r_dist <= n_dist;
    end

    assign o_agg = r_agg;

endmodule

>>> rtl/template_min_hamming_filter_core.sv
// ============================================================================
// template_min_hamming_filter_core : template min-Hamming-distance filter
// Chain of template cells; grams update all cells at once, and survivor
// count and best template are gathered by a token sweeping the chain.
// ============================================================================
//  channel | dir | handshake        | payload
//  i_req   | in  | valid / ready    | func, word, initial_distance
//  o_res   | out | valid / ready    | kind, survivors, best_template,
//          |     |                  | best_distance, none_live
//  i_cfg   | in  | i_cfg_we         | i_cfg_wdata (keep floor)
//
//  A load or an unknown request needs no sweep. In a gram or report request
//  the aggregate moves one cell per cycle down the chain, then through a
//  hold register into the output register once any waiting result is taken.
//  Reset clears live flags, load count and control; the keep floor resets to 2.
//  A waiting result does not block the sweep of the next request.
// ============================================================================
module template_min_hamming_filter_core
    import tmhf_pkg::*;
#(
    parameter int NUM_TEMPLATES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tmhf_req_if.sink          i_req,
    tmhf_res_if.source        o_res,
    input  logic              i_cfg_we,
    input  logic [DIST_W-1:0] i_cfg_wdata
);

    localparam int CNT_W = $clog2(NUM_TEMPLATES + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_PEND  = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic              r_launch;
    logic [CNT_W-1:0]  r_loaded;
    logic [DIST_W-1:0] r_keep_floor;
    logic              r_kind;
    t_agg              r_hold;

    logic              r_out_valid;
    logic              r_out_kind;
    logic [SURV_W-1:0] r_out_survivors;
    logic [WORD_W-1:0] r_out_best_template;
    logic [DIST_W-1:0] r_out_best_distance;
    logic              r_out_none_live;

    logic              w_accept;
    logic              w_is_gram;
    logic              w_is_report;
    logic              w_load;
    logic              w_move;
    t_cell_cmd         w_cmd;
    t_agg              w_chain [NUM_TEMPLATES+1];
    logic [NUM_TEMPLATES-1:0] w_load_vec;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_is_gram   = (i_req.func == FUNC_GRAM);
    assign w_is_report = (i_req.func == FUNC_REPORT);
    assign w_load      = w_accept && (i_req.func == FUNC_LOAD)
                         && (r_loaded < CNT_W'(NUM_TEMPLATES));
    assign w_move      = (r_state == ST_PEND) && (!r_out_valid || o_res.ready);

    // command broadcast to all cells
    always_comb begin
        w_cmd.gram       = w_accept && w_is_gram;
        w_cmd.word       = i_req.word;
        w_cmd.init       = i_req.initial_distance;
        w_cmd.keep_floor = r_keep_floor;
    end

    // chain seed: token enters the first cell the cycle after accept
    always_comb begin
        w_chain[0]       = '0;
        w_chain[0].valid = r_launch;
    end

    // cell chain
    for (genvar g = 0; g < NUM_TEMPLATES; g++) begin : g_cell
        assign w_load_vec[g] = w_load && (r_loaded == CNT_W'(g));
        tmhf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (w_load_vec[g]),
            .i_cmd   (w_cmd),
            .i_agg   (w_chain[g]),
            .o_agg   (w_chain[g+1])
        );
    end

    // sequencing
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (w_is_gram || w_is_report)) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (w_chain[NUM_TEMPLATES].valid) begin
                    n_state = ST_PEND;
                end
            end
            ST_PEND: begin
                if (w_move) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_launch     <= 1'b0;
            r_loaded     <= '0;
            r_keep_floor <= DIST_W'(2);
            r_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= w_accept && (w_is_gram || w_is_report);
            if (w_load) begin
                r_loaded <= r_loaded + CNT_W'(1);
            end
            if (i_cfg_we) begin
                r_keep_floor <= i_cfg_wdata;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request kind and chain result hold
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= w_is_report ? KIND_REPORT : KIND_GRAM;
        end
        if ((r_state == ST_SWEEP) && w_chain[NUM_TEMPLATES].valid) begin
            r_hold <= w_chain[NUM_TEMPLATES];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_kind      <= r_kind;
            r_out_survivors <= r_hold.count;
            if ((r_kind == KIND_REPORT) && r_hold.found) begin
                r_out_best_template <= r_hold.tmpl;
                r_out_best_distance <= r_hold.best_dist;
            end else begin
                r_out_best_template <= '0;
                r_out_best_distance <= '0;
            end
            r_out_none_live <= (r_kind == KIND_REPORT) && !r_hold.found;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.kind          = r_out_kind;
    assign o_res.survivors     = r_out_survivors;
    assign o_res.best_template = r_out_best_template;
    assign o_res.best_distance = r_out_best_distance;
    assign o_res.none_live     = r_out_none_live;

endmodule

>>> rtl/tmhf_checker.sv
// ============================================================================
// tmhf_checker : port-level checks for the template filter
// Result channel hold rules and consistency of result fields.
// ============================================================================
module tmhf_checker
    import tmhf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_in_func,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_kind,
    input logic [6:0]  i_out_survivors,
    input logic [63:0] i_out_best_template,
    input logic [5:0]  i_out_best_distance,
    input logic        i_out_none_live
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_survivors)
            && $stable(i_out_best_template) && $stable(i_out_kind))
        else $error("result payload changed while stalled");

    // empty report carries no template and no survivors
    a_none_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_none_live |-> i_out_survivors == 7'd0
            && i_out_best_template == 64'd0 && i_out_best_distance == 6'd0
            && i_out_kind == KIND_REPORT)
        else $error("empty report inconsistent");

    // gram results leave the report fields clear
    a_gram_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_GRAM |-> !i_out_none_live
            && i_out_best_distance == 6'd0 && i_out_best_template == 64'd0)
        else $error("gram result carries report fields");

    // a gram request is never followed directly by another request
    a_gram_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_func == FUNC_GRAM |=> !i_in_ready)
        else $error("request taken during sweep");

endmodule

bind template_min_hamming_filter_core tmhf_checker u_tmhf_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_req.valid),
    .i_in_ready          (i_req.ready),
    .i_in_func           (i_req.func),
    .i_out_valid         (o_res.valid),
    .i_out_ready         (o_res.ready),
    .i_out_kind          (o_res.kind),
    .i_out_survivors     (o_res.survivors),
    .i_out_best_template (o_res.best_template),
    .i_out_best_distance (o_res.best_distance),
    .i_out_none_live     (o_res.none_live)
);
